[sv/oasc_pkg.sv]
// Shared constants and the arctangent table for the octonion arctan soft clipper.
// Used by octonion_arctan_soft_clip_core; depends on nothing else.
package oasc_pkg;

    localparam int DATA_W    = 32;             // component width, signed Q16.16
    localparam int FRAC_W    = 16;             // fraction bits of a component
    localparam int LIM_W     = DATA_W - 1;     // clip limit width, unsigned
    localparam int LANES     = 8;              // octonion components
    localparam int ITERS     = 56;             // CORDIC iterations
    localparam int GUARD     = 8;              // guard bits below the input LSB
    localparam int K8_W      = 39;             // width of the scaled limit K8
    localparam int CW        = 43;             // CORDIC x/y width, signed
    localparam int ZW        = 64;             // angle accumulator width, Q62 signed
    localparam int R_W       = 34;             // rounded magnitude width
    localparam int PIPE_LEN  = ITERS + 4;      // flag/valid stages ahead of output

    // round(2^32 * 2/pi)
    localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;
    // pi * 2^60, i.e. atan(1) in Q62
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    localparam logic [LIM_W-1:0] RESET_LIMIT = LIM_W'(1) << FRAC_W;
    localparam logic [K8_W-1:0]  K8_RESET    =
        K8_W'((64'(RESET_LIMIT) * 64'(TWO_OVER_PI_Q32)) >> 24);

    typedef logic signed [CW-1:0] cord_t;
    typedef logic signed [ZW-1:0] ang_t;

    // One power-of-two term of the atan series, zero once the exponent runs out
    function automatic logic [63:0] atan_pow(input int i, input int k);
        int s;
        s = i * (2 * k + 1);
        if (s > 62)
        begin
            return 64'd0;
        end
        return 64'd1 << (62 - s);
    endfunction

    // atan(2^-i) in Q62, truncated alternating series
    function automatic logic [63:0] atan_q62(input int i);
        logic [63:0] acc;
        if (i == 0)
        begin
            return PI_Q60;
        end
        acc = atan_pow(i, 0)
            - atan_pow(i, 1) / 3   + atan_pow(i, 2) / 5   - atan_pow(i, 3) / 7
            + atan_pow(i, 4) / 9   - atan_pow(i, 5) / 11  + atan_pow(i, 6) / 13
            - atan_pow(i, 7) / 15  + atan_pow(i, 8) / 17  - atan_pow(i, 9) / 19
            + atan_pow(i, 10) / 21 - atan_pow(i, 11) / 23 + atan_pow(i, 12) / 25
            - atan_pow(i, 13) / 27 + atan_pow(i, 14) / 29 - atan_pow(i, 15) / 31
            + atan_pow(i, 16) / 33 - atan_pow(i, 17) / 35 + atan_pow(i, 18) / 37
            - atan_pow(i, 19) / 39 + atan_pow(i, 20) / 41 - atan_pow(i, 21) / 43
            + atan_pow(i, 22) / 45 - atan_pow(i, 23) / 47 + atan_pow(i, 24) / 49
            - atan_pow(i, 25) / 51 + atan_pow(i, 26) / 53 - atan_pow(i, 27) / 55
            + atan_pow(i, 28) / 57 - atan_pow(i, 29) / 59 + atan_pow(i, 30) / 61;
        return acc;
    endfunction

endpackage

[sv/octonion_arctan_soft_clip_core.sv]
// Octonion arctan soft clipper: eight lanes of y = K*atan(x/K), K = 2M/pi.
// Depends on oasc_pkg for widths, constants and the arctangent table.
//
// Usage:
//   Input channel: drive in_r .. in_g and raise start; the beat is taken at
//   a rising edge with start high and busy low. busy stays low, so one
//   octonion can enter on every cycle.
//   Output channel: done is high for exactly one cycle with out_r .. out_g;
//   results come out in the order the beats went in.
//   Pipeline: the accepting edge loads the input register; 56 CORDIC
//   stages, three multiply/round stages and one sign/output stage follow
//   it, and done rises with the output register. Throughput is one octonion
//   per cycle, set by the fully pipelined 56-stage vectoring CORDIC.
//   Configuration: clip_limit_we writes clip_limit (M, unsigned Q15.16) and
//   the scaled limit K8 in the same edge; a write of zero stores one. Write
//   only while no beat is in flight.
//   Reset: clears the valid pipeline and done, and sets M to 1.0.
//   The receiver cannot stall; results are never held back.
module octonion_arctan_soft_clip_core
    import oasc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    output logic                     done,
    input  logic                     clip_limit_we,
    input  logic [LIM_W-1:0]         clip_limit,
    input  logic signed [DATA_W-1:0] in_r,
    input  logic signed [DATA_W-1:0] in_a,
    input  logic signed [DATA_W-1:0] in_b,
    input  logic signed [DATA_W-1:0] in_c,
    input  logic signed [DATA_W-1:0] in_d,
    input  logic signed [DATA_W-1:0] in_e,
    input  logic signed [DATA_W-1:0] in_f,
    input  logic signed [DATA_W-1:0] in_g,
    output logic signed [DATA_W-1:0] out_r,
    output logic signed [DATA_W-1:0] out_a,
    output logic signed [DATA_W-1:0] out_b,
    output logic signed [DATA_W-1:0] out_c,
    output logic signed [DATA_W-1:0] out_d,
    output logic signed [DATA_W-1:0] out_e,
    output logic signed [DATA_W-1:0] out_f,
    output logic signed [DATA_W-1:0] out_g
);

    // Configuration registers
    logic [LIM_W-1:0]    limit_reg;
    logic [K8_W-1:0]     k8_reg;
    logic [LIM_W-1:0]    limit_next;
    logic [62:0]         k8_prod;

    // Pipeline control and lane flags
    logic                valid_reg [0:PIPE_LEN-1];
    logic [LANES-1:0]    neg_reg   [0:PIPE_LEN-1];
    logic [LANES-1:0]    zero_reg  [0:PIPE_LEN-1];
    logic                done_reg;

    // Lane datapath
    logic signed [DATA_W-1:0] in_lane [0:LANES-1];
    logic [DATA_W-1:0]        mag     [0:LANES-1];
    cord_t                    y0_reg  [0:LANES-1];
    cord_t                    cx_reg  [0:LANES-1][1:ITERS-1];
    cord_t                    cy_reg  [0:LANES-1][1:ITERS-1];
    ang_t                     cz_reg  [0:LANES-1][1:ITERS];
    logic [62:0]              zc      [0:LANES-1];
    logic [63:0]              pll_reg [0:LANES-1];
    logic [62:0]              plh_reg [0:LANES-1];
    logic [38:0]              phl_reg [0:LANES-1];
    logic [37:0]              phh_reg [0:LANES-1];
    logic [37:0]              phh2_reg[0:LANES-1];
    logic [64:0]              mid_reg [0:LANES-1];
    logic [K8_W-1:0]          hi      [0:LANES-1];
    logic [39:0]              hi_rnd  [0:LANES-1];
    logic [R_W-1:0]           r_reg   [0:LANES-1];
    logic [LIM_W-1:0]         rc      [0:LANES-1];
    logic signed [DATA_W-1:0] out_reg [0:LANES-1];

    // The pipeline never stalls, so the input side is always open
    assign busy = 1'b0;
    assign done = done_reg;

    // Scale the new limit: K8 = floor(M * (2/pi) * 2^8) in input LSBs
    assign limit_next = (clip_limit == '0) ? LIM_W'(1) : clip_limit;
    assign k8_prod    = 63'(limit_next) * 63'(TWO_OVER_PI_Q32);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= RESET_LIMIT;
            k8_reg    <= K8_RESET;
        end
        else if (clip_limit_we)
        begin
            limit_reg <= limit_next;
            k8_reg    <= k8_prod[62:24];
        end
    end

    // Advance the valid bits; done marks the output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < PIPE_LEN; n++)
            begin
                valid_reg[n] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= start && !busy;
            for (int n = 1; n < PIPE_LEN; n++)
            begin
                valid_reg[n] <= valid_reg[n-1];
            end
            done_reg <= valid_reg[PIPE_LEN-1];
        end
    end

    // Gather the input components into lanes
    assign in_lane[0] = in_r;
    assign in_lane[1] = in_a;
    assign in_lane[2] = in_b;
    assign in_lane[3] = in_c;
    assign in_lane[4] = in_d;
    assign in_lane[5] = in_e;
    assign in_lane[6] = in_f;
    assign in_lane[7] = in_g;

    // Shift the sign and zero flags alongside the data
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            neg_reg[0][l]  <= in_lane[l][DATA_W-1];
            zero_reg[0][l] <= (in_lane[l] == '0);
        end
        for (int n = 1; n < PIPE_LEN; n++)
        begin
            neg_reg[n]  <= neg_reg[n-1];
            zero_reg[n] <= zero_reg[n-1];
        end
    end

    genvar gl, gi;
    generate
        for (gl = 0; gl < LANES; gl++)
        begin : g_lane
            // Take the magnitude; the most negative value stays 2^31
            assign mag[gl] = in_lane[gl][DATA_W-1] ? DATA_W'(-in_lane[gl])
                                                   : DATA_W'(in_lane[gl]);

            always_ff @(posedge clk)
            begin
                y0_reg[gl] <= cord_t'({mag[gl], GUARD'(0)});
            end

            // Vectoring CORDIC, one iteration per stage
            for (gi = 0; gi < ITERS; gi++)
            begin : g_iter
                localparam logic [63:0] ATAN_I = atan_q62(gi);

                if (gi == 0)
                begin : g_first
                    // y starts non-negative, so the first turn is always clockwise
                    always_ff @(posedge clk)
                    begin
                        cx_reg[gl][1] <= cord_t'(k8_reg) + y0_reg[gl];
                        cy_reg[gl][1] <= y0_reg[gl] - cord_t'(k8_reg);
                        cz_reg[gl][1] <= ang_t'(ATAN_I);
                    end
                end
                else if (gi == ITERS - 1)
                begin : g_last
                    // Only the angle is needed from the final iteration
                    always_ff @(posedge clk)
                    begin
                        if (!cy_reg[gl][gi][CW-1])
                        begin
                            cz_reg[gl][gi+1] <= cz_reg[gl][gi] + ang_t'(ATAN_I);
                        end
                        else
                        begin
                            cz_reg[gl][gi+1] <= cz_reg[gl][gi] - ang_t'(ATAN_I);
                        end
                    end
                end
                else
                begin : g_mid
                    always_ff @(posedge clk)
                    begin
                        if (!cy_reg[gl][gi][CW-1])
                        begin
                            cx_reg[gl][gi+1] <= cx_reg[gl][gi] + (cy_reg[gl][gi] >>> gi);
                            cy_reg[gl][gi+1] <= cy_reg[gl][gi] - (cx_reg[gl][gi] >>> gi);
                            cz_reg[gl][gi+1] <= cz_reg[gl][gi] + ang_t'(ATAN_I);
                        end
                        else
                        begin
                            cx_reg[gl][gi+1] <= cx_reg[gl][gi] - (cy_reg[gl][gi] >>> gi);
                            cy_reg[gl][gi+1] <= cy_reg[gl][gi] + (cx_reg[gl][gi] >>> gi);
                            cz_reg[gl][gi+1] <= cz_reg[gl][gi] - ang_t'(ATAN_I);
                        end
                    end
                end
            end

            // Clamp the angle at zero, then form K8 * z as four partial products
            assign zc[gl] = cz_reg[gl][ITERS][ZW-1] ? 63'd0 : cz_reg[gl][ITERS][62:0];

            always_ff @(posedge clk)
            begin
                pll_reg[gl] <= 64'(k8_reg[31:0]) * 64'(zc[gl][31:0]);
                plh_reg[gl] <= 63'(k8_reg[31:0]) * 63'(zc[gl][62:32]);
                phl_reg[gl] <= 39'(k8_reg[38:32]) * 39'(zc[gl][31:0]);
                phh_reg[gl] <= 38'(k8_reg[38:32]) * 38'(zc[gl][62:32]);
            end

            // Sum the middle column; hold the top product
            always_ff @(posedge clk)
            begin
                mid_reg[gl]  <= 65'(pll_reg[gl][63:32]) + 65'(plh_reg[gl])
                              + 65'(phl_reg[gl]);
                phh2_reg[gl] <= phh_reg[gl];
            end

            // Take the high word of the product and round away 6 more bits
            assign hi[gl]     = K8_W'(phh2_reg[gl]) + K8_W'(mid_reg[gl][64:32]);
            assign hi_rnd[gl] = 40'(hi[gl]) + 40'd32;

            always_ff @(posedge clk)
            begin
                r_reg[gl] <= hi_rnd[gl][39:6];
            end

            // Keep the result strictly inside the bound, then restore the sign
            assign rc[gl] = (r_reg[gl] >= R_W'(limit_reg)) ? (limit_reg - LIM_W'(1))
                                                           : r_reg[gl][LIM_W-1:0];

            always_ff @(posedge clk)
            begin
                if (zero_reg[PIPE_LEN-1][gl])
                begin
                    out_reg[gl] <= '0;
                end
                else if (neg_reg[PIPE_LEN-1][gl])
                begin
                    out_reg[gl] <= -DATA_W'(rc[gl]);
                end
                else
                begin
                    out_reg[gl] <= DATA_W'(rc[gl]);
                end
            end
        end
    endgenerate

    // Drive the result ports
    assign out_r = out_reg[0];
    assign out_a = out_reg[1];
    assign out_b = out_reg[2];
    assign out_c = out_reg[3];
    assign out_d = out_reg[4];
    assign out_e = out_reg[5];
    assign out_f = out_reg[6];
    assign out_g = out_reg[7];

endmodule

[bench/tb_octonion_arctan_soft_clip_core.sv]
// Self-checking testbench for octonion_arctan_soft_clip_core: directed table, then random beats.
// Depends on oasc_pkg and the core; predicts each lane with a bit-exact CORDIC arctangent.
module tb_octonion_arctan_soft_clip_core;
    import oasc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Lane 0 is the real part, lanes 1..7 the imaginary parts a..g
    typedef logic [0:LANES-1][DATA_W-1:0] oct_t;

    typedef struct packed {
        logic             wr;     // write clip_limit ahead of the beat
        logic [LIM_W-1:0] lim;
        oct_t             din;
        logic             typed;  // expectation given in the row itself
        oct_t             dout;
    } dir_row_t;

    localparam logic [DATA_W-1:0] POS_MAX = 32'h7FFFFFFF;
    localparam logic [DATA_W-1:0] NEG_MAX = 32'h80000000;
    localparam logic [DATA_W-1:0] P_ONE   = 32'h00010000;
    localparam logic [DATA_W-1:0] N_ONE   = 32'hFFFF0000;
    localparam logic [DATA_W-1:0] N_LSB   = 32'hFFFFFFFF;
    localparam oct_t              ZERO_OCT = '0;
    localparam int                END_WAIT = PIPE_LEN + 10;
    localparam int                SEND_IDLE_PCT [3] = '{6, 52, 0};

    localparam int N_DIR = 14;
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        // zero input after reset, M = 1.0
        '{1'b0, 31'd0, {8{32'd0}}, 1'b1, {8{32'd0}}},
        '{1'b0, 31'd0, {POS_MAX, NEG_MAX, 32'd1, N_LSB, P_ONE, N_ONE, 32'h7FFF0000, 32'd0},
          1'b0, {8{32'd0}}},
        '{1'b0, 31'd0, {32'd2, 32'hFFFFFFFE, 32'h00008000, 32'hFFFF8000,
                        32'h00020000, 32'hFFFD0000, 32'h00100000, 32'hFFF00000},
          1'b0, {8{32'd0}}},
        // a zero limit is stored as one, so every lane clamps to zero
        '{1'b1, 31'd0, {POS_MAX, NEG_MAX, 32'd1, N_LSB, P_ONE, N_ONE, 32'd0, 32'd12345},
          1'b1, {8{32'd0}}},
        '{1'b1, 31'd1, {POS_MAX, NEG_MAX, 32'd1, N_LSB, P_ONE, N_ONE, 32'd7, 32'hFFFFFFF9},
          1'b1, {8{32'd0}}},
        '{1'b1, 31'd2, {POS_MAX, NEG_MAX, 32'd1, N_LSB, P_ONE, N_ONE, 32'd2, 32'hFFFFFFFE},
          1'b0, {8{32'd0}}},
        '{1'b0, 31'd0, {32'd1, N_LSB, 32'd2, 32'hFFFFFFFE, 32'd3, 32'hFFFFFFFD, POS_MAX, NEG_MAX},
          1'b0, {8{32'd0}}},
        // largest bound: near-identity for small inputs
        '{1'b1, 31'h7FFFFFFF, {POS_MAX, NEG_MAX, 32'd1, N_LSB, P_ONE, N_ONE,
                               32'h40000000, 32'hC0000000},
          1'b0, {8{32'd0}}},
        '{1'b0, 31'd0, {32'h5555AAAA, 32'hAAAA5555, 32'h0F0F0F0F, 32'hF0F0F0F0,
                        32'h33333333, 32'hCCCCCCCC, 32'h00FF00FF, 32'hFF00FF00},
          1'b0, {8{32'd0}}},
        '{1'b1, 31'h40000000, {POS_MAX, NEG_MAX, 32'h40000000, 32'hC0000000,
                               32'h3FFFFFFF, 32'hC0000001, P_ONE, N_ONE},
          1'b0, {8{32'd0}}},
        '{1'b1, 31'h00010000, {8{32'd0}}, 1'b1, {8{32'd0}}},
        '{1'b0, 31'd0, {POS_MAX, POS_MAX, POS_MAX, POS_MAX, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX},
          1'b0, {8{32'd0}}},
        '{1'b1, 31'h00008000, {P_ONE, N_ONE, 32'h00004000, 32'hFFFFC000,
                               32'h00008000, 32'hFFFF8000, POS_MAX, NEG_MAX},
          1'b0, {8{32'd0}}},
        '{1'b1, 31'h00010000, {P_ONE, N_ONE, 32'h00018000, 32'hFFFE8000,
                               32'h00000100, 32'hFFFFFF00, 32'h00200000, 32'hFFE00000},
          1'b0, {8{32'd0}}}
    };

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             lim_we    = 1'b0;
    logic [LIM_W-1:0] lim_wdata = '0;
    oct_t             oct_in    = '0;
    logic             busy;
    logic             done;
    oct_t             oct_out;

    // predictor copy of the register and its scaled form
    logic [LIM_W-1:0]  lim_now;
    longint unsigned   k8_now;
    longint            atan_q62_tab [ITERS];
    oct_t              clipped_q [$];
    int                n_mismatch = 0;

    octonion_arctan_soft_clip_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .done          (done),
        .clip_limit_we (lim_we),
        .clip_limit    (lim_wdata),
        .in_r          (oct_in[0]),
        .in_a          (oct_in[1]),
        .in_b          (oct_in[2]),
        .in_c          (oct_in[3]),
        .in_d          (oct_in[4]),
        .in_e          (oct_in[5]),
        .in_f          (oct_in[6]),
        .in_g          (oct_in[7]),
        .out_r         (oct_out[0]),
        .out_a         (oct_out[1]),
        .out_b         (oct_out[2]),
        .out_c         (oct_out[3]),
        .out_d         (oct_out[4]),
        .out_e         (oct_out[5]),
        .out_f         (oct_out[6]),
        .out_g         (oct_out[7])
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Build atan(2^-i) in Q62 from the truncated alternating series
    initial
    begin
        longint unsigned acc;
        longint unsigned term;
        atan_q62_tab[0] = longint'(PI_Q60);
        for (int i = 1; i < ITERS; i++)
        begin
            acc = 0;
            for (int k = 0; i * (2 * k + 1) <= 62; k++)
            begin
                term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
                acc  = (k % 2 == 1) ? acc - term : acc + term;
            end
            atan_q62_tab[i] = longint'(acc);
        end
    end

    // K = 2M/pi in input LSBs with eight guard bits
    function automatic longint unsigned scaled_limit(input logic [LIM_W-1:0] m);
        longint unsigned mh;
        longint unsigned ml;
        mh = 64'(m) >> 16;
        ml = 64'(m) & 64'hFFFF;
        return (mh * 64'(TWO_OVER_PI_Q32) + ((ml * 64'(TWO_OVER_PI_Q32)) >> 16)) >> 8;
    endfunction

    // Squash one component: vectoring CORDIC on (K, |x|), then K*angle rounded
    function automatic logic [DATA_W-1:0] clip_component(input logic [DATA_W-1:0] raw);
        logic            neg;
        longint unsigned mag;
        longint          x;
        longint          y;
        longint          z;
        longint          dx;
        longint          dy;
        logic [127:0]    prod;
        longint unsigned r;
        neg = raw[DATA_W-1];
        mag = neg ? (64'd1 << DATA_W) - 64'(raw) : 64'(raw);
        if (mag == 0)
        begin
            return '0;
        end
        x = longint'(k8_now);
        y = longint'(mag << GUARD);
        z = 0;
        for (int i = 0; i < ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += atan_q62_tab[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= atan_q62_tab[i];
            end
        end
        if (z < 0)
        begin
            z = 0;
        end
        prod = 128'(k8_now) * 128'($unsigned(z));
        r = (prod[127:64] + 64'd32) >> 6;
        // hold the magnitude strictly below the bound
        if (r >= 64'(lim_now))
        begin
            r = 64'(lim_now) - 64'd1;
        end
        return neg ? DATA_W'(-r) : DATA_W'(r);
    endfunction

    function automatic oct_t clip_octonion(input oct_t v);
        oct_t res;
        for (int j = 0; j < LANES; j++)
        begin
            res[j] = clip_component(v[j]);
        end
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] rand_component();
        int unsigned sel;
        logic [DATA_W-1:0] v;
        sel = $urandom_range(15);
        case (sel)
            0: return '0;
            1: return POS_MAX;
            2: return NEG_MAX;
            3: return $urandom_range(1) ? N_LSB : 32'd1;
            4, 5, 6, 7: return $urandom();
            default:
            begin
                v = $urandom() >> $urandom_range(31);
                return $urandom_range(1) ? -v : v;
            end
        endcase
    endfunction

    function automatic logic [LIM_W-1:0] rand_limit();
        case ($urandom_range(7))
            0: return '0;
            1: return LIM_W'(1);
            2: return {LIM_W{1'b1}};
            3: return RESET_LIMIT;
            4, 5: return LIM_W'($urandom());
            default: return LIM_W'($urandom() >> $urandom_range(31));
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        n_mismatch++;
    endtask

    // Drop start and hold off until every expected beat has come back
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (clipped_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_clip_limit(input logic [LIM_W-1:0] m);
        drain_results();
        @(negedge clk);
        lim_we    <= 1'b1;
        lim_wdata <= m;
        @(negedge clk);
        lim_we    <= 1'b0;
        lim_now = (m == '0) ? LIM_W'(1) : m;
        k8_now  = scaled_limit(lim_now);
    endtask

    // Present one beat and queue its expectation once it is taken
    task automatic send_octonion(input oct_t v, input logic typed, input oct_t want);
        @(negedge clk);
        start  <= 1'b1;
        oct_in <= v;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        clipped_q.push_back(typed ? want : clip_octonion(v));
    endtask

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        oct_t want;
        if (rst_n && done)
        begin
            if (clipped_q.size() == 0)
            begin
                report_mismatch("result beat with nothing in flight");
            end
            else
            begin
                want = clipped_q.pop_front();
                for (int j = 0; j < LANES; j++)
                begin
                    if (oct_out[j] !== want[j])
                    begin
                        report_mismatch($sformatf("lane %0d got %h want %h",
                                                  j, oct_out[j], want[j]));
                    end
                end
            end
        end
    end

    initial
    begin
        dir_row_t row;
        oct_t     v;
        int       p_idle;
        lim_now = RESET_LIMIT;
        k8_now  = scaled_limit(RESET_LIMIT);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int n = 0; n < N_DIR; n++)
        begin
            row = DIR_ROWS[n];
            if (row.wr)
            begin
                set_clip_limit(row.lim);
            end
            send_octonion(row.din, row.typed, row.dout);
        end

        // random beats: three idle profiles, a new limit every block
        for (int ph = 0; ph < 3; ph++)
        begin
            p_idle = SEND_IDLE_PCT[ph];
            for (int blk = 0; blk < 6; blk++)
            begin
                set_clip_limit(rand_limit());
                for (int n = 0; n < 64; n++)
                begin
                    while ($urandom_range(99) < p_idle)
                    begin
                        @(negedge clk);
                        start <= 1'b0;
                    end
                    for (int j = 0; j < LANES; j++)
                    begin
                        v[j] = rand_component();
                    end
                    send_octonion(v, 1'b0, ZERO_OCT);
                end
            end
        end

        drain_results();
        repeat (END_WAIT) @(posedge clk);
        if (clipped_q.size() != 0)
        begin
            report_mismatch("expected beats left over");
        end
        if (n_mismatch == 0)
        begin
            $display("tb_octonion_arctan_soft_clip_core OK");
        end
        else
        begin
            $display("tb_octonion_arctan_soft_clip_core NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("tb_octonion_arctan_soft_clip_core NOT OK");
        $finish;
    end

endmodule
